// ===== design/block_buffer_cache_manager_macros.svh =====
// Assertion macros used by the buffer cache manager top level.
`ifndef BLOCK_BUFFER_CACHE_MANAGER_MACROS_SVH
`define BLOCK_BUFFER_CACHE_MANAGER_MACROS_SVH

// Implication in the same cycle, checked on every rising edge outside reset.
`define BBCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define BBCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bbcm_pkg.sv =====
// Types, codes and helpers shared by the buffer cache manager.
package bbcm_pkg;

  localparam int NUM_BUFFERS_DEF = 64;
  localparam int IDX_W           = 6;
  localparam int DEV_W           = 16;
  localparam int BLK_W           = 31;
  localparam int REF_W           = 8;

  localparam logic [2:0] REQ_GET     = 3'd0;
  localparam logic [2:0] REQ_RELEASE = 3'd1;
  localparam logic [2:0] REQ_SETF    = 3'd2;
  localparam logic [2:0] REQ_INV     = 3'd3;
  localparam logic [2:0] REQ_SYNC    = 3'd4;

  localparam logic [3:0] ST_HIT      = 4'd0;
  localparam logic [3:0] ST_ALLOC    = 4'd1;
  localparam logic [3:0] ST_BUSY     = 4'd2;
  localparam logic [3:0] ST_NONE     = 4'd3;
  localparam logic [3:0] ST_RELEASED = 4'd4;
  localparam logic [3:0] ST_ERROR    = 4'd5;
  localparam logic [3:0] ST_FLAGS    = 4'd6;
  localparam logic [3:0] ST_INVAL    = 4'd7;
  localparam logic [3:0] ST_WBACK    = 4'd8;
  localparam logic [3:0] ST_SYNCED   = 4'd9;

  typedef enum logic [4:0] {
    S_IDLE, S_HIT_RD, S_HIT_CHK, S_ORD_RD, S_ORD_CHK, S_VIC_CHK, S_DECIDE,
    S_SHIFT_RD, S_SHIFT_WR, S_IDX_RD, S_IDX_CHK, S_INV_RD, S_INV_CHK,
    S_SYNC_RD, S_SYNC_CHK, S_SYNC_END, S_OUT
  } state_t;

  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [BLK_W-1:0] blk;
    logic [REF_W-1:0] refs;
    logic             dirty;
    logic             locked;
    logic             uptodate;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0] rd_addr;
    logic             wr;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } ent_cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] rd_addr;
    logic             wr;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_data;
  } ord_cmd_t;

  typedef struct packed {
    logic [3:0]       status;
    logic [IDX_W-1:0] idx;
    logic             dirty;
    logic             locked;
    logic             uptodate;
    logic [REF_W-1:0] refs;
    logic             last;
  } res_t;

  function automatic res_t mk_res(logic [3:0] status, logic [IDX_W-1:0] idx,
                                  entry_t e, logic show, logic last);
    res_t r;
    r.status   = status;
    r.idx      = idx;
    r.dirty    = show & e.dirty;
    r.locked   = show & e.locked;
    r.uptodate = show & e.uptodate;
    r.refs     = show ? e.refs : '0;
    r.last     = last;
    return r;
  endfunction

endpackage

// ===== design/bbcm_store.sv =====
// Entry tag memory and allocation order memory with per-entry valid bits.
module bbcm_store import bbcm_pkg::*; #(
  parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  ent_cmd_t         ent_cmd,
  input  ord_cmd_t         ord_cmd,
  output entry_t           ent_rdata,
  output logic [IDX_W-1:0] ord_rdata
);

  localparam int AW = $clog2(NUM_BUFFERS);

  entry_t           ent_mem [NUM_BUFFERS];
  logic [AW-1:0]    ord_mem [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] ent_vld;
  logic [NUM_BUFFERS-1:0] ord_vld;
  entry_t           ent_q;
  logic             ent_vld_q;
  logic [AW-1:0]    ord_q;
  logic             ord_vld_q;
  logic [AW-1:0]    ord_addr_q;

  always_ff @(posedge clk) begin
    if (ent_cmd.wr) begin
      ent_mem[ent_cmd.wr_addr[AW-1:0]] <= ent_cmd.wr_data;
    end
    if (ord_cmd.wr) begin
      ord_mem[ord_cmd.wr_addr[AW-1:0]] <= ord_cmd.wr_data[AW-1:0];
    end
    ent_q      <= ent_mem[ent_cmd.rd_addr[AW-1:0]];
    ord_q      <= ord_mem[ord_cmd.rd_addr[AW-1:0]];
    ord_addr_q <= ord_cmd.rd_addr[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld   <= '0;
      ord_vld   <= '0;
      ent_vld_q <= 1'b0;
      ord_vld_q <= 1'b0;
    end else begin
      if (ent_cmd.wr) begin
        ent_vld[ent_cmd.wr_addr[AW-1:0]] <= 1'b1;
      end
      if (ord_cmd.wr) begin
        ord_vld[ord_cmd.wr_addr[AW-1:0]] <= 1'b1;
      end
      ent_vld_q <= ent_vld[ent_cmd.rd_addr[AW-1:0]];
      ord_vld_q <= ord_vld[ord_cmd.rd_addr[AW-1:0]];
    end
  end

  // An entry never written reads as all zero; an order slot never written holds its own position.
  assign ent_rdata = ent_vld_q ? ent_q : '0;
  assign ord_rdata = IDX_W'(ord_vld_q ? ord_q : ord_addr_q);

endmodule

// ===== design/block_buffer_cache_manager.sv =====
// Top level of the buffer cache tag and replacement engine.
//
//   channel   direction  handshake            word
//   request   in         in_valid / in_ready  req_type, dev_id, block_num, entry_index, flags
//   result    out        out_valid/out_ready  status, result_index, entry flags, refs, last
//
// One request is taken at a time; in_ready is high only when the sequencer is idle.
// Each entry visit reads the tag memory before checking it, as the read port is registered.
// A hit lookup walks the entries in index order; a miss then walks the allocation order for a
// victim and, once one is claimed, closes the order behind it.
// Release and set flags read and update the named entry; invalidate and sync scan every entry,
// and sync emits one writeback word for each matching dirty entry that it finds.
// Reset takes effect at once: valid bits make unwritten entries read as their reset value.
// A stalled result holds the sequencer; a sync scan resumes when each word is taken.
module block_buffer_cache_manager import bbcm_pkg::*; #(
  parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       req_type,
  input  logic [DEV_W-1:0] dev_id,
  input  logic [BLK_W-1:0] block_num,
  input  logic [IDX_W-1:0] entry_index,
  input  logic             dirty_in,
  input  logic             locked_in,
  input  logic             uptodate_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [3:0]       status,
  output logic [IDX_W-1:0] result_index,
  output logic             entry_dirty,
  output logic             entry_locked,
  output logic             entry_uptodate,
  output logic [REF_W-1:0] entry_refs,
  output logic             last_result
);

`include "block_buffer_cache_manager_macros.svh"

  localparam int AW = $clog2(NUM_BUFFERS);
  localparam logic [AW-1:0] LAST = AW'(NUM_BUFFERS - 1);

  state_t state, state_next, rtn, rtn_next;
  logic [AW-1:0] cnt, cnt_next;

  // Latched request word.
  logic [2:0]       r_type;
  logic [DEV_W-1:0] r_dev;
  logic [BLK_W-1:0] r_blk;
  logic [IDX_W-1:0] r_idx;
  logic             r_d, r_l, r_u;

  // Victim search and sync bookkeeping.
  logic             best_found, best_found_next;
  logic [AW-1:0]    best_pos, best_pos_next;
  logic [AW-1:0]    best_e, best_e_next;
  logic [1:0]       best_bad, best_bad_next;
  entry_t           best_ent, best_ent_next;
  logic [AW-1:0]    cur_e, cur_e_next;
  logic             pend_vld, pend_vld_next;
  logic [AW-1:0]    pend_idx, pend_idx_next;
  entry_t           pend_ent, pend_ent_next;

  res_t res, res_next;

  ent_cmd_t         ent_cmd;
  ord_cmd_t         ord_cmd;
  entry_t           ent_q;
  logic [IDX_W-1:0] ord_q;

  entry_t     upd;
  logic [1:0] bad;
  logic       sync_hit;
  state_t     sync_go;

  bbcm_store #(.NUM_BUFFERS(NUM_BUFFERS)) u_store (
    .clk       (clk),
    .rst       (rst),
    .ent_cmd   (ent_cmd),
    .ord_cmd   (ord_cmd),
    .ent_rdata (ent_q),
    .ord_rdata (ord_q)
  );

  // Dirty weighs two and locked one when a victim is chosen.
  assign bad      = {ent_q.dirty, ent_q.locked};
  assign sync_hit = ((r_dev == '0) || (ent_q.dev == r_dev)) && ent_q.dirty;
  assign sync_go  = (cnt == LAST) ? S_SYNC_END : S_SYNC_RD;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rtn        <= S_IDLE;
      best_found <= 1'b0;
      pend_vld   <= 1'b0;
    end else begin
      state      <= state_next;
      rtn        <= rtn_next;
      best_found <= best_found_next;
      pend_vld   <= pend_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt      <= cnt_next;
    best_pos <= best_pos_next;
    best_e   <= best_e_next;
    best_bad <= best_bad_next;
    best_ent <= best_ent_next;
    cur_e    <= cur_e_next;
    pend_idx <= pend_idx_next;
    pend_ent <= pend_ent_next;
    res      <= res_next;
    if (in_valid && in_ready) begin
      r_type <= req_type;
      r_dev  <= dev_id;
      r_blk  <= block_num;
      r_idx  <= entry_index;
      r_d    <= dirty_in;
      r_l    <= locked_in;
      r_u    <= uptodate_in;
    end
  end

  always_comb begin
    state_next      = state;
    rtn_next        = rtn;
    cnt_next        = cnt;
    best_found_next = best_found;
    best_pos_next   = best_pos;
    best_e_next     = best_e;
    best_bad_next   = best_bad;
    best_ent_next   = best_ent;
    cur_e_next      = cur_e;
    pend_vld_next   = pend_vld;
    pend_idx_next   = pend_idx;
    pend_ent_next   = pend_ent;
    res_next        = res;
    upd             = ent_q;
    ent_cmd         = '0;
    ord_cmd         = '0;
    ent_cmd.rd_addr = IDX_W'(cnt);
    ord_cmd.rd_addr = IDX_W'(cnt);
    in_ready        = 1'b0;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cnt_next        = '0;
          rtn_next        = S_IDLE;
          best_found_next = 1'b0;
          pend_vld_next   = 1'b0;
          case (req_type)
            REQ_GET: begin
              // Device zero never hits, so the lookup is skipped.
              state_next = (dev_id != '0) ? S_HIT_RD : S_ORD_RD;
            end
            REQ_RELEASE, REQ_SETF: begin
              if ({1'b0, entry_index} >= (IDX_W + 1)'(NUM_BUFFERS)) begin
                res_next   = mk_res(ST_ERROR, entry_index, '0, 1'b0, 1'b1);
                state_next = S_OUT;
              end else begin
                state_next = S_IDX_RD;
              end
            end
            REQ_INV:  state_next = S_INV_RD;
            REQ_SYNC: state_next = S_SYNC_RD;
            default:  state_next = S_IDLE;
          endcase
        end
      end

      S_HIT_RD: state_next = S_HIT_CHK;

      S_HIT_CHK: begin
        if ((ent_q.dev == r_dev) && (ent_q.blk == r_blk)) begin
          if (ent_q.refs != '1) begin
            upd.refs = ent_q.refs + REF_W'(1);
          end
          ent_cmd.wr      = 1'b1;
          ent_cmd.wr_addr = IDX_W'(cnt);
          ent_cmd.wr_data = upd;
          res_next        = mk_res(ST_HIT, IDX_W'(cnt), upd, 1'b1, 1'b1);
          state_next      = S_OUT;
        end else if (cnt == LAST) begin
          cnt_next   = '0;
          state_next = S_ORD_RD;
        end else begin
          cnt_next   = cnt + AW'(1);
          state_next = S_HIT_RD;
        end
      end

      S_ORD_RD: state_next = S_ORD_CHK;

      S_ORD_CHK: begin
        cur_e_next      = ord_q[AW-1:0];
        ent_cmd.rd_addr = ord_q;
        state_next      = S_VIC_CHK;
      end

      S_VIC_CHK: begin
        // Entries in use are skipped; the first of the lowest badness wins.
        if ((ent_q.refs == '0) && (!best_found || (bad < best_bad))) begin
          best_found_next = 1'b1;
          best_pos_next   = cnt;
          best_e_next     = cur_e;
          best_bad_next   = bad;
          best_ent_next   = ent_q;
        end
        if ((ent_q.refs == '0) && (bad == 2'd0)) begin
          state_next = S_DECIDE;
        end else if (cnt == LAST) begin
          state_next = S_DECIDE;
        end else begin
          cnt_next   = cnt + AW'(1);
          state_next = S_ORD_RD;
        end
      end

      S_DECIDE: begin
        if (!best_found) begin
          res_next   = mk_res(ST_NONE, '0, '0, 1'b0, 1'b1);
          state_next = S_OUT;
        end else if (best_bad != 2'd0) begin
          res_next   = mk_res(ST_BUSY, IDX_W'(best_e), best_ent, 1'b1, 1'b1);
          state_next = S_OUT;
        end else begin
          upd.dev      = r_dev;
          upd.blk      = r_blk;
          upd.refs     = REF_W'(1);
          upd.dirty    = 1'b0;
          upd.locked   = best_ent.locked;
          upd.uptodate = 1'b0;
          ent_cmd.wr      = 1'b1;
          ent_cmd.wr_addr = IDX_W'(best_e);
          ent_cmd.wr_data = upd;
          res_next   = mk_res(ST_ALLOC, IDX_W'(best_e), upd, 1'b1, 1'b1);
          cnt_next   = best_pos;
          state_next = S_SHIFT_RD;
        end
      end

      // Close the gap in the allocation order and put the victim at the tail.
      S_SHIFT_RD: begin
        if (cnt == LAST) begin
          ord_cmd.wr      = 1'b1;
          ord_cmd.wr_addr = IDX_W'(cnt);
          ord_cmd.wr_data = IDX_W'(best_e);
          state_next      = S_OUT;
        end else begin
          ord_cmd.rd_addr = IDX_W'(cnt + AW'(1));
          state_next      = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        ord_cmd.wr      = 1'b1;
        ord_cmd.wr_addr = IDX_W'(cnt);
        ord_cmd.wr_data = ord_q;
        cnt_next        = cnt + AW'(1);
        state_next      = S_SHIFT_RD;
      end

      S_IDX_RD: begin
        ent_cmd.rd_addr = r_idx;
        state_next      = S_IDX_CHK;
      end

      S_IDX_CHK: begin
        ent_cmd.wr_addr = r_idx;
        if (r_type == REQ_RELEASE) begin
          if (ent_q.refs == '0) begin
            res_next = mk_res(ST_ERROR, r_idx, ent_q, 1'b1, 1'b1);
          end else begin
            upd.refs        = ent_q.refs - REF_W'(1);
            ent_cmd.wr      = 1'b1;
            ent_cmd.wr_data = upd;
            res_next        = mk_res(ST_RELEASED, r_idx, upd, 1'b1, 1'b1);
          end
        end else begin
          upd.dirty       = r_d;
          upd.locked      = r_l;
          upd.uptodate    = r_u;
          ent_cmd.wr      = 1'b1;
          ent_cmd.wr_data = upd;
          res_next        = mk_res(ST_FLAGS, r_idx, upd, 1'b1, 1'b1);
        end
        state_next = S_OUT;
      end

      S_INV_RD: state_next = S_INV_CHK;

      S_INV_CHK: begin
        if (ent_q.dev == r_dev) begin
          upd.dirty       = 1'b0;
          upd.uptodate    = 1'b0;
          ent_cmd.wr      = 1'b1;
          ent_cmd.wr_addr = IDX_W'(cnt);
          ent_cmd.wr_data = upd;
        end
        if (cnt == LAST) begin
          res_next   = mk_res(ST_INVAL, '0, '0, 1'b0, 1'b1);
          state_next = S_OUT;
        end else begin
          cnt_next   = cnt + AW'(1);
          state_next = S_INV_RD;
        end
      end

      S_SYNC_RD: state_next = S_SYNC_CHK;

      // A found entry is held back one step so that the final word can carry last.
      S_SYNC_CHK: begin
        cnt_next   = cnt + AW'(1);
        state_next = sync_go;
        if (sync_hit) begin
          pend_vld_next = 1'b1;
          pend_idx_next = cnt;
          pend_ent_next = ent_q;
          if (pend_vld) begin
            res_next   = mk_res(ST_WBACK, IDX_W'(pend_idx), pend_ent, 1'b1, 1'b0);
            rtn_next   = sync_go;
            state_next = S_OUT;
          end
        end
      end

      S_SYNC_END: begin
        if (pend_vld) begin
          res_next = mk_res(ST_WBACK, IDX_W'(pend_idx), pend_ent, 1'b1, 1'b1);
        end else begin
          res_next = mk_res(ST_SYNCED, '0, '0, 1'b0, 1'b1);
        end
        rtn_next   = S_IDLE;
        state_next = S_OUT;
      end

      S_OUT: begin
        if (out_ready) begin
          state_next = rtn;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid      = (state == S_OUT);
  assign status         = res.status;
  assign result_index   = res.idx;
  assign entry_dirty    = res.dirty;
  assign entry_locked   = res.locked;
  assign entry_uptodate = res.uptodate;
  assign entry_refs     = res.refs;
  assign last_result    = res.last;

  `BBCM_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "request taken while a result is pending")
  `BBCM_ASSERT_NOW(a_alloc_fields, out_valid && (status == ST_ALLOC), (entry_refs == REF_W'(1)) && !entry_dirty && !entry_uptodate, "claimed entry not fresh")
  `BBCM_ASSERT_NOW(a_none_zero, out_valid && (status == ST_NONE), (entry_refs == '0) && (result_index == '0), "none free result not cleared")
  `BBCM_ASSERT_NEXT(a_last_idle, out_valid && out_ready && last_result, in_ready, "sequencer busy after final result")

endmodule
